// ===== hdl/scd_pkg.sv =====
// ----------------------------------------------------------------------------
// scd_pkg: shared types and constants for the shifted column cosine distance
// Request structs, function codes, register indexes and fixed widths.
// ----------------------------------------------------------------------------
package scd_pkg;

  localparam int DEF_MAX_RINGS   = 32;
  localparam int DEF_MAX_SECTORS = 64;

  localparam logic [5:0] RING_COUNT_RESET   = 6'd20;
  localparam logic [6:0] SECTOR_COUNT_RESET = 7'd60;

  // Cosine scale, Q1.16
  localparam int COS_FRAC = 16;

  // Function codes
  typedef enum logic [1:0] {
    FUNC_LOAD_TARGET = 2'd0,
    FUNC_LOAD_QUERY  = 2'd1,
    FUNC_COMPUTE     = 2'd2,
    FUNC_UNUSED      = 2'd3
  } func_t;

  // Register indexes
  localparam logic REG_RING_COUNT   = 1'b0;
  localparam logic REG_SECTOR_COUNT = 1'b1;

  typedef struct packed {
    logic [1:0]         func;
    logic [4:0]         ring_index;
    logic [5:0]         sector_index;
    logic signed [11:0] bin_value;
  } in_req_t;

  typedef struct packed {
    logic [17:0] distance;
    logic [5:0]  win_shift;
    logic        found;
  } out_req_t;

  typedef struct packed {
    logic       index;
    logic [6:0] data;
  } cfg_req_t;

endpackage

// ===== hdl/shifted_column_cosine_distance.sv =====
// ----------------------------------------------------------------------------
// shifted_column_cosine_distance: best circular column shift by cosine distance
//
// in_* (valid/ready) carries a target bin load, a query bin load or a compute
// request. A load is written at its accepting edge and gives no result; loads
// may follow one per cycle. A compute runs a sequencer over shared
// accumulators, a bit-serial square root and a bit-serial divider: column
// norms first, then per shift and per column pair a skip when a column is
// empty or else dot product, norm product, square root and division, then
// per shift a mean and a best-shift update. in_ready stays low meanwhile.
// out_* (valid/ready) holds the result in registers until taken; a stalled
// receiver keeps the block in that state and blocks the next request.
// cfg_* writes ring_count (index 0) or sector_count (index 1); the user must
// write only while idle, the block itself does not enforce it. Values above
// the maximum saturate. rst (synchronous) restores the registers and starts a
// clearing pass over both bin memories; no request is taken until it ends.
// ----------------------------------------------------------------------------
module shifted_column_cosine_distance
  import scd_pkg::*;
#(
  parameter int MAX_RINGS   = DEF_MAX_RINGS,
  parameter int MAX_SECTORS = DEF_MAX_SECTORS
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_req_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  cfg_req_t cfg_data
);

  localparam int RW    = (MAX_RINGS > 1) ? $clog2(MAX_RINGS) : 1;
  localparam int SW    = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
  localparam int AW    = RW + SW;
  localparam int DEPTH = MAX_RINGS * MAX_SECTORS;
  localparam int RCW   = $clog2(MAX_RINGS + 1);
  localparam int SCW   = $clog2(MAX_SECTORS + 1);
  // norm: up to MAX_RINGS * 2^22
  localparam int NW    = 22 + RCW;
  localparam int DW    = NW + 1;          // signed dot
  localparam int PW    = 2 * NW;          // norm product
  localparam int QW    = (PW + 1) / 2;    // sqrt width
  localparam int CW    = 18;              // 1 - cos, 0..131072
  localparam int SUMW  = CW + 2 * SW + 1;
  localparam int VW    = 2 * SW + 2;
  localparam int NUMW  = DW + COS_FRAC;   // |dot| << 16
  localparam int SQC   = $clog2(QW + 1);
  localparam int DVC   = $clog2(NUMW + 1);

  typedef enum logic [12:0] {
    ST_CLEAR  = 13'b0000000000001,
    ST_IDLE   = 13'b0000000000010,
    ST_NORM   = 13'b0000000000100,
    ST_SHIFT  = 13'b0000000001000,
    ST_PAIR   = 13'b0000000010000,
    ST_DOT    = 13'b0000000100000,
    ST_SQ_MUL = 13'b0000001000000,
    ST_SQRT   = 13'b0000010000000,
    ST_DIV    = 13'b0000100000000,
    ST_ACC    = 13'b0001000000000,
    ST_MEAN   = 13'b0010000000000,
    ST_BEST   = 13'b0100000000000,
    ST_OUT    = 13'b1000000000000
  } state_t;

  state_t state;

  // Configuration
  logic [5:0] ring_count;
  logic [6:0] sector_count;
  logic [RCW-1:0] r_lim;
  logic [SCW-1:0] s_lim;

  // Bin memories and column norm memories
  logic signed [11:0] tmem [DEPTH];
  logic signed [11:0] qmem [DEPTH];
  logic [NW-1:0] ntmem [MAX_SECTORS];
  logic [NW-1:0] nqmem [MAX_SECTORS];
  logic signed [11:0] t_rd, q_rd;
  logic [NW-1:0] nt_rd, nq_rd;

  // Sequencer counters
  logic [AW-1:0]  clr_addr;
  logic [SCW-1:0] col, shift;
  logic [SW-1:0]  qcol;
  logic [RCW-1:0] row;
  logic           rd_pend;   // read issued last cycle, data valid now
  logic [SQC-1:0] sq_cnt;
  logic [DVC-1:0] dv_cnt;

  // Shared accumulator
  logic signed [DW-1:0] acc_a;   // dot or target norm
  logic [NW-1:0]        acc_b;   // query norm
  logic [PW-1:0]        rad;     // sqrt radicand
  logic [QW-1:0]        root;
  logic [PW+1:0]        sq_rem;
  logic [NUMW-1:0]      dv_quo;
  logic [NUMW:0]        dv_rem;
  logic [QW-1:0]        dv_den;
  logic                 dv_neg;
  logic [SUMW-1:0]      sum;
  logic [VW-1:0]        valid_cnt;
  logic [17:0]          best;
  logic [SW-1:0]        win_shift;
  logic                 found;
  out_req_t             out_reg;

  logic in_fire, cfg_fire;
  logic [RW-1:0] rd_row;
  logic [SW-1:0] rd_col;

  assign r_lim = (32'(ring_count) > MAX_RINGS) ? RCW'(MAX_RINGS) : RCW'(ring_count);
  assign s_lim = (32'(sector_count) > MAX_SECTORS) ? SCW'(MAX_SECTORS) : SCW'(sector_count);

  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid;
  assign out_valid = (state == ST_OUT);
  assign out_data  = out_reg;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_count   <= RING_COUNT_RESET;
      sector_count <= SECTOR_COUNT_RESET;
    end else if (cfg_fire) begin
      if (cfg_data.index == REG_RING_COUNT) ring_count <= cfg_data.data[5:0];
      else sector_count <= cfg_data.data;
    end
  end

  // Memory read address: norm pass reads column col, dot pass reads col/qcol
  assign rd_row = row[RW-1:0];
  assign rd_col = col[SW-1:0];

  // Bin memories: one write port, registered reads
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      tmem[clr_addr] <= '0;
      qmem[clr_addr] <= '0;
    end else if (in_fire && 32'(in_data.ring_index) < MAX_RINGS &&
                 32'(in_data.sector_index) < MAX_SECTORS) begin
      if (in_data.func == FUNC_LOAD_TARGET)
        tmem[{in_data.ring_index[RW-1:0], in_data.sector_index[SW-1:0]}] <=
          in_data.bin_value;
      else if (in_data.func == FUNC_LOAD_QUERY)
        qmem[{in_data.ring_index[RW-1:0], in_data.sector_index[SW-1:0]}] <=
          in_data.bin_value;
    end
    t_rd <= tmem[{rd_row, rd_col}];
    q_rd <= qmem[{rd_row, (state == ST_NORM) ? rd_col : qcol}];
  end

  // Norm memories: store the column sums including the last row
  always_ff @(posedge clk) begin
    if (state == ST_NORM && rd_pend && row == r_lim) begin
      ntmem[rd_col] <= NW'(acc_a + DW'(prod_tt));
      nqmem[rd_col] <= acc_b + NW'(prod_qq);
    end
    nt_rd <= ntmem[rd_col];
    nq_rd <= nqmem[qcol];
  end

  // Products of the bin multipliers
  logic signed [23:0] prod_tq, prod_tt, prod_qq;
  assign prod_tq = t_rd * q_rd;
  assign prod_tt = t_rd * t_rd;
  assign prod_qq = q_rd * q_rd;

  // sqrt trial and divide trial
  logic [PW+1:0] sq_trial;
  logic [NUMW:0] dv_trial;
  logic [SCW:0]  qsum;
  assign sq_trial = {sq_rem[PW-1:0], rad[PW-1 -: 2]} - {{(PW+2-QW-2){1'b0}}, root, 2'b01};
  assign dv_trial = {dv_rem[NUMW-1:0], dv_quo[NUMW-1]};
  assign qsum     = {1'b0, col} + {1'b0, shift};

  // Cos after clamp, and 1 - cos
  logic [NUMW-1:0] cmag;
  logic [CW-1:0]   one_minus;
  assign cmag = (dv_quo > NUMW'(65536)) ? NUMW'(65536) : dv_quo;
  assign one_minus = dv_neg ? CW'(65536 + cmag) : CW'(65536 - cmag);

  // Mean division: reuse the divider registers over sum / valid_cnt
  logic [SUMW:0] mn_trial;
  assign mn_trial = {dv_rem[SUMW-1:0], sum[SUMW-1]};

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      rd_pend  <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (32'(clr_addr) == DEPTH - 1) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_fire && in_data.func == FUNC_COMPUTE) begin
            col <= '0; row <= '0; rd_pend <= 1'b0;
            acc_a <= '0; acc_b <= '0;
            found <= 1'b0; best <= '0; win_shift <= '0;
            state <= (r_lim == '0 || s_lim == '0) ? ST_OUT : ST_NORM;
          end
        end
        // Column norms: read one row per cycle, accumulate squares
        ST_NORM: begin
          if (rd_pend && row == r_lim) begin
            acc_a <= '0; acc_b <= '0; row <= '0; rd_pend <= 1'b0;
            if (col == s_lim - 1'b1) begin
              shift <= '0;
              state <= ST_SHIFT;
            end else col <= col + 1'b1;
          end else begin
            rd_pend <= 1'b1;
            row <= row + 1'b1;
            if (rd_pend) begin
              acc_a <= acc_a + DW'(prod_tt);
              acc_b <= acc_b + NW'(prod_qq);
            end
          end
        end
        ST_SHIFT: begin
          col <= '0; sum <= '0; valid_cnt <= '0;
          qcol <= SW'(shift);
          state <= ST_PAIR;
        end
        // Let the registered norm reads settle before the dot product
        ST_PAIR: begin
          row <= '0; rd_pend <= 1'b0; acc_a <= '0;
          state <= ST_DOT;
        end
        ST_DOT: begin
          if (nt_rd == '0 || nq_rd == '0) state <= ST_ACC;
          else begin
            rd_pend <= (row != r_lim);
            if (row != r_lim) row <= row + 1'b1;
            if (rd_pend) acc_a <= acc_a + DW'(prod_tq);
            if (rd_pend && row == r_lim) state <= ST_SQ_MUL;
          end
        end
        ST_SQ_MUL: begin
          rad    <= PW'(nt_rd) * PW'(nq_rd);
          sq_rem <= '0;
          root   <= '0;
          sq_cnt <= '0;
          state  <= ST_SQRT;
        end
        // Restoring square root, one result bit per cycle
        ST_SQRT: begin
          rad <= rad << 2;
          if (!sq_trial[PW+1]) begin
            sq_rem <= sq_trial;
            root   <= {root[QW-2:0], 1'b1};
          end else begin
            sq_rem <= {sq_rem[PW-1:0], rad[PW-1 -: 2]};
            root   <= {root[QW-2:0], 1'b0};
          end
          sq_cnt <= sq_cnt + 1'b1;
          if (32'(sq_cnt) == QW - 1) begin
            dv_neg <= acc_a[DW-1];
            dv_quo <= {(acc_a[DW-1] ? DW'(-acc_a) : DW'(acc_a)), {COS_FRAC{1'b0}}};
            dv_rem <= '0;
            dv_cnt <= '0;
            state  <= ST_DIV;
          end
        end
        // Restoring division |dot|<<16 / den, one quotient bit per cycle
        ST_DIV: begin
          if (dv_cnt == '0 && root == '0) dv_den <= QW'(1);
          else if (dv_cnt == '0) dv_den <= root;
          if (dv_cnt != '0) begin
            if (dv_trial >= {{(NUMW+1-QW){1'b0}}, dv_den}) begin
              dv_rem <= dv_trial - {{(NUMW+1-QW){1'b0}}, dv_den};
              dv_quo <= {dv_quo[NUMW-2:0], 1'b1};
            end else begin
              dv_rem <= dv_trial;
              dv_quo <= {dv_quo[NUMW-2:0], 1'b0};
            end
          end
          dv_cnt <= dv_cnt + 1'b1;
          if (32'(dv_cnt) == NUMW) state <= ST_ACC;
        end
        // Accumulate this pair, advance column
        ST_ACC: begin
          if (nt_rd != '0 && nq_rd != '0) begin
            sum <= sum + SUMW'(one_minus);
            valid_cnt <= valid_cnt + 1'b1;
          end
          if (col == s_lim - 1'b1) begin
            dv_rem <= '0; dv_cnt <= '0;
            state  <= ST_MEAN;
          end else begin
            col   <= col + 1'b1;
            qcol  <= (qsum + 1'b1 >= {1'b0, s_lim}) ? SW'(qsum + 1'b1 - s_lim)
                                                   : SW'(qsum + 1'b1);
            state <= ST_PAIR;
          end
        end
        // Mean: sum / valid_cnt, one bit per cycle (quotient shifted into sum)
        ST_MEAN: begin
          if (valid_cnt == '0) state <= ST_BEST;
          else begin
            if (mn_trial >= (SUMW+1)'(valid_cnt)) begin
              dv_rem <= (NUMW+1)'(mn_trial - (SUMW+1)'(valid_cnt));
              sum    <= {sum[SUMW-2:0], 1'b1};
            end else begin
              dv_rem <= (NUMW+1)'(mn_trial);
              sum    <= {sum[SUMW-2:0], 1'b0};
            end
            dv_cnt <= dv_cnt + 1'b1;
            if (32'(dv_cnt) == SUMW - 1) state <= ST_BEST;
          end
        end
        ST_BEST: begin
          if (valid_cnt != '0 && (!found || 18'(sum) < best)) begin
            found <= 1'b1;
            best <= 18'(sum);
            win_shift <= SW'(shift);
          end
          if (shift == s_lim - 1'b1) state <= ST_OUT;
          else begin
            shift <= shift + 1'b1;
            state <= ST_SHIFT;
          end
        end
        ST_OUT: begin
          if (out_ready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result output, formed combinationally from the found, best and win_shift registers
  always_comb begin
    out_reg.distance  = found ? best : '0;
    out_reg.win_shift = found ? 6'(win_shift) : '0;
    out_reg.found     = found;
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.distance <= 18'd131072) else $error("distance range");
  a_nf_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.found) |-> (out_data.distance == '0 && out_data.win_shift == '0))
    else $error("not found but nonzero");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
`endif

endmodule

// ===== test/shifted_column_cosine_distance_tb.sv =====
// ----------------------------------------------------------------------------
// shifted_column_cosine_distance_tb: self-checking bench for the column shift
// cosine distance block
//
// Loads target and query bins, writes the ring and sector counts and issues
// compute requests. A behavioral predictor tracks both bin arrays and the
// counts, and works out the best shift and mean distance for each compute.
// Results are checked in order against the predicted queue. The sender and
// receiver both insert random gaps, and one test stalls the receiver for a long
// stretch while computes keep coming.
// ----------------------------------------------------------------------------
module shifted_column_cosine_distance_tb;
  import scd_pkg::*;

  localparam int  RING_MAX   = 32;
  localparam int  SECTOR_MAX = 64;
  localparam int  ONE_Q16    = 65536;
  localparam int  CYCLE_LIMIT = 8_000_000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_req_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  cfg_req_t cfg_data = '0;

  // Predictor state
  logic signed [11:0] tgt_bins [RING_MAX][SECTOR_MAX];
  logic signed [11:0] qry_bins [RING_MAX][SECTOR_MAX];
  logic [5:0]         ring_cfg;
  logic [6:0]         sector_cfg;
  out_req_t           pending_results[$];

  int  error_count = 0;
  int  cycle_count = 0;
  int  stall_left  = 0;
  int  hold_left   = 0;
  bit  hold_on     = 1'b0;
  bit  calm        = 1'b0;

  shifted_column_cosine_distance u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 17);
  endfunction

  // Floor of the square root, bit by bit
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Best circular shift by mean cosine distance over nonzero column pairs
  function automatic out_req_t predict_result();
    int       rows, cols, qc, best_s;
    longint   nt[SECTOR_MAX];
    longint   nq[SECTOR_MAX];
    longint   dot, den, cosv, sum, cnt, mean, best;
    bit       fnd;
    out_req_t res;
    rows = (ring_cfg > RING_MAX) ? RING_MAX : ring_cfg;
    cols = (sector_cfg > SECTOR_MAX) ? SECTOR_MAX : sector_cfg;
    fnd = 1'b0;
    best = 0;
    best_s = 0;
    for (int c = 0; c < cols; c++) begin
      nt[c] = 0;
      nq[c] = 0;
      for (int r = 0; r < rows; r++) begin
        nt[c] += longint'(tgt_bins[r][c]) * longint'(tgt_bins[r][c]);
        nq[c] += longint'(qry_bins[r][c]) * longint'(qry_bins[r][c]);
      end
    end
    for (int s = 0; s < cols; s++) begin
      sum = 0;
      cnt = 0;
      for (int c = 0; c < cols; c++) begin
        qc = (c + s) % cols;
        if (nt[c] == 0 || nq[qc] == 0) continue;
        dot = 0;
        for (int r = 0; r < rows; r++)
          dot += longint'(tgt_bins[r][c]) * longint'(qry_bins[r][qc]);
        den = longint'(root_floor(nt[c] * nq[qc]));
        if (den < 1) den = 1;
        cosv = (dot * ONE_Q16) / den;
        if (cosv > ONE_Q16) cosv = ONE_Q16;
        if (cosv < -ONE_Q16) cosv = -ONE_Q16;
        sum += ONE_Q16 - cosv;
        cnt++;
      end
      if (cnt == 0) continue;
      mean = sum / cnt;
      if (!fnd || mean < best) begin
        fnd = 1'b1;
        best = mean;
        best_s = s;
      end
    end
    res.distance  = fnd ? best[17:0] : '0;
    res.win_shift = fnd ? best_s[5:0] : '0;
    res.found     = fnd;
    return res;
  endfunction

  // Send one request, then update the predictor on acceptance
  task automatic send_request(func_t f, logic [4:0] r, logic [5:0] s,
                              logic signed [11:0] v);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.func         <= f;
    in_data.ring_index   <= r;
    in_data.sector_index <= s;
    in_data.bin_value    <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (f)
      FUNC_LOAD_TARGET: tgt_bins[r][s] = v;
      FUNC_LOAD_QUERY:  qry_bins[r][s] = v;
      FUNC_COMPUTE:     pending_results.insert(pending_results.size(), predict_result());
      default: ;
    endcase
  endtask

  // Drop valid and wait until every result has been taken
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [6:0] d);
    settle();
    cfg_valid <= 1'b1;
    cfg_data.index <= idx;
    cfg_data.data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_RING_COUNT) ring_cfg = d[5:0];
    else sector_cfg = d;
  endtask

  task automatic compute();
    send_request(FUNC_COMPUTE, 5'($urandom), 6'($urandom), 12'($urandom));
  endtask

  // Long receiver hold, counted down on its own
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      hold_on <= 1'b1;
    end else begin
      hold_on <= 1'b0;
    end
  end

  // Result check and receiver stalls
  always @(posedge clk) begin
    out_req_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result %p", $time, out_data);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (want.distance !== out_data.distance)
          $display("%0t distance exp %0d got %0d", $time, want.distance,
                   out_data.distance);
        if (want.win_shift !== out_data.win_shift)
          $display("%0t win_shift exp %0d got %0d", $time, want.win_shift,
                   out_data.win_shift);
        if (want.found !== out_data.found)
          $display("%0t found exp %0d got %0d", $time, want.found,
                   out_data.found);
        if (want !== out_data) error_count++;
      end
      stall_left = draw_wait();
    end
    if (hold_on) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Empty arrays, saturation, zero counts, unused code, far bins
  task automatic test_directed();
    write_reg(REG_RING_COUNT, 7'd2);
    write_reg(REG_SECTOR_COUNT, 7'd3);
    compute();
    send_request(FUNC_LOAD_TARGET, 5'd0, 6'd0, 12'sd2047);
    send_request(FUNC_LOAD_TARGET, 5'd1, 6'd1, -12'sd2048);
    send_request(FUNC_LOAD_QUERY, 5'd0, 6'd1, -12'sd2048);
    send_request(FUNC_LOAD_QUERY, 5'd1, 6'd2, 12'sd2047);
    send_request(FUNC_LOAD_QUERY, 5'd31, 6'd63, 12'sd5);
    send_request(FUNC_LOAD_TARGET, 5'd31, 6'd63, -12'sd1);
    send_request(FUNC_UNUSED, 5'd31, 6'd63, 12'sd7);
    compute();
    write_reg(REG_RING_COUNT, 7'd0);
    compute();
    write_reg(REG_RING_COUNT, 7'd127);
    write_reg(REG_SECTOR_COUNT, 7'd0);
    compute();
    write_reg(REG_SECTOR_COUNT, 7'd2);
    compute();
    // Widest setting, one ring to keep it short
    write_reg(REG_RING_COUNT, 7'd1);
    write_reg(REG_SECTOR_COUNT, 7'd127);
    send_request(FUNC_LOAD_TARGET, 5'd0, 6'd63, 12'sd300);
    send_request(FUNC_LOAD_QUERY, 5'd0, 6'd62, -12'sd9);
    compute();
  endtask

  // Random load sequences at small sizes, with unused codes, out-of-range loads and occasional computes, then a compute
  task automatic test_random(int phases);
    int rows, cols, n, pick;
    logic signed [11:0] v;
    for (int p = 0; p < phases; p++) begin
      calm = ($urandom_range(0, 3) == 0);
      rows = $urandom_range(1, 8);
      cols = $urandom_range(1, 6);
      write_reg(REG_RING_COUNT, rows[6:0]);
      write_reg(REG_SECTOR_COUNT, cols[6:0]);
      n = $urandom_range(20, 50);
      for (int i = 0; i < n; i++) begin
        pick = $urandom_range(0, 9);
        case ($urandom_range(0, 3))
          0: v = '0;
          1: v = 12'($urandom_range(0, 15) - 8);
          default: v = 12'($urandom);
        endcase
        if (pick == 0)
          send_request(FUNC_UNUSED, 5'($urandom), 6'($urandom), 12'($urandom));
        else if (pick == 1)
          send_request($urandom_range(0, 1) ? FUNC_LOAD_QUERY : FUNC_LOAD_TARGET,
                       5'($urandom), 6'($urandom), v);
        else if (pick == 2 && i % 7 == 0)
          compute();
        else
          send_request($urandom_range(0, 1) ? FUNC_LOAD_QUERY : FUNC_LOAD_TARGET,
                       5'($urandom_range(0, rows - 1)), 6'($urandom_range(0, cols - 1)),
                       v);
      end
      compute();
    end
  endtask

  // Receiver holds off while computes keep arriving
  task automatic test_backpressure();
    write_reg(REG_RING_COUNT, 7'd3);
    write_reg(REG_SECTOR_COUNT, 7'd4);
    calm = 1'b1;
    hold_left = 6000;
    for (int i = 0; i < 4; i++) begin
      send_request(FUNC_LOAD_QUERY, 5'($urandom_range(0, 2)), 6'($urandom_range(0, 3)),
                   12'($urandom));
      compute();
    end
    calm = 1'b0;
  endtask

  initial begin
    for (int r = 0; r < RING_MAX; r++)
      for (int s = 0; s < SECTOR_MAX; s++) begin
        tgt_bins[r][s] = '0;
        qry_bins[r][s] = '0;
      end
    ring_cfg = RING_COUNT_RESET;
    sector_cfg = SECTOR_COUNT_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random(44);
    settle();
    repeat (50) @(posedge clk);
    if (error_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
